// ===== rtl/c8fed_pkg.sv =====
// Shared constants for the CHIP-8 fetch/execute/draw core.
package c8fed_pkg;

  // Default sizes of the program RAM and the frame store
  localparam int RAM_BYTES_DEF = 4096;
  localparam int SCREEN_W_DEF  = 64;
  localparam int SCREEN_H_DEF  = 32;

  // Architectural constants
  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] WORD_CLS = 16'h00E0;
  localparam logic [3:0]  VF_IDX   = 4'hF;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_WRITE_RAM = 2'd0,
    KIND_EXECUTE   = 2'd1,
    KIND_READ_ROW  = 2'd2,
    KIND_READ_REG  = 2'd3
  } kind_t;

  // Top nibble of the instruction word
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JUMP = 4'h1;
  localparam logic [3:0] OP_SETV = 4'h6;
  localparam logic [3:0] OP_ADDV = 4'h7;
  localparam logic [3:0] OP_SETI = 4'hA;
  localparam logic [3:0] OP_DRAW = 4'hD;

endpackage

// ===== rtl/chip8_fetch_execute_draw_top.sv =====
// Top level of the CHIP-8 fetch/execute/draw core with program RAM and frame store.
//
// Each transfer on the item channel carries one action: write a program RAM byte,
// execute one instruction, read one frame row, or read one V register; each
// returns exactly one transfer on the result channel. A small sequencer walks
// every item through three memories (program RAM, V register file, frame store,
// each with one write port and one registered read port) and one shared shifter
// that places a sprite byte on a frame row. The item channel stalls from the
// transfer until the result is loaded into the output register; a finished
// result waiting on a stalled result channel does not block the next item
// transfer, but the next item's final step waits until that register drains. An
// item passes through these steps: a RAM write is done at acceptance; a row or
// register read takes one memory read; execute fetches the word with two RAM
// reads, 7XNN then reads and writes VX, and DXYN reads VX and VY, clears VF and
// does one RAM read and one frame read-modify-write per sprite row, at most 15.
// Pixels past the right or bottom edge are clipped and never collide. The frame
// store and V registers read as zero after reset, and the frame store again after
// a screen clear (per-row and per-register valid bits); program RAM reads are only
// defined once written.
module chip8_fetch_execute_draw_top #(
  parameter int RAM_BYTES = c8fed_pkg::RAM_BYTES_DEF,
  parameter int SCREEN_W  = c8fed_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H  = c8fed_pkg::SCREEN_H_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [4:0]  row_select,
  input  logic [3:0]  reg_select,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] pc_now,
  output logic [11:0] index_now,
  output logic [15:0] opcode_run,
  output logic        collision,
  output logic [63:0] row_bits,
  output logic [7:0]  reg_value
);

  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam int ROW_AW = $clog2(SCREEN_H);
  localparam int XW     = $clog2(SCREEN_W);
  localparam int YSW    = $clog2(SCREEN_H + 15);

  typedef enum logic [3:0] {
    IDLE, FETCH_A, FETCH_B, DECODE, ADD_RD, ADD_WR, DRAW_X, DRAW_Y, DRAW_Z,
    ROW_RD, ROW_WR, ROW_GET, REG_GET, FINISH
  } state_t;

  // Reduce a value modulo m by conditional subtraction of m*16 .. m*1.
  // Every caller keeps its value below 32*m.
  function automatic logic [19:0] fold(input logic [19:0] v, input logic [19:0] m);
    logic [19:0] r;
    r = v;
    for (int k = 4; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return r;
  endfunction

  state_t               state;
  logic [11:0]          pc;
  logic [11:0]          index;
  logic [7:0]           vf;
  logic [15:0]          opcode;
  logic [7:0]           op_hi;
  logic [XW-1:0]        x0;
  logic [ROW_AW-1:0]    y0;
  logic [3:0]           draw_i;
  logic [4:0]           row_sel;
  logic [63:0]          res_row;
  logic [7:0]           res_reg;
  logic [15:0]          vvalid;
  logic [SCREEN_H-1:0]  fvalid;
  logic                 v_rok;
  logic                 f_rok;

  // memories
  logic [7:0]           ram_mem [RAM_BYTES];
  logic [7:0]           ram_q;
  logic [7:0]           v_mem [16];
  logic [7:0]           v_q;
  logic [SCREEN_W-1:0]  frame_mem [SCREEN_H];
  logic [SCREEN_W-1:0]  frame_q;

  // combinational controls
  logic                 accept;
  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [RAM_AW-1:0]    ram_raddr;
  logic                 v_we;
  logic [3:0]           v_waddr;
  logic [7:0]           v_wdata;
  logic [3:0]           v_raddr;
  logic                 f_we;
  logic [ROW_AW-1:0]    f_raddr;
  logic [SCREEN_W-1:0]  f_wdata;
  logic [15:0]          dec_word;
  logic [7:0]           v_eff;
  logic [SCREEN_W-1:0]  frame_eff;
  logic [YSW-1:0]       y_sum;
  logic [11:0]          spr_addr;
  logic [SCREEN_W+7:0]  spr_wide;
  logic [SCREEN_W-1:0]  spr_mask;
  logic                 hit;
  logic                 draw_done;

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  assign dec_word   = {op_hi, ram_q};
  assign v_eff      = v_rok ? v_q : 8'h00;
  assign frame_eff  = f_rok ? frame_q : '0;
  assign y_sum      = YSW'(y0) + YSW'(draw_i);
  assign spr_addr   = index + 12'(draw_i);
  assign draw_done  = (draw_i == opcode[3:0]) || (y_sum >= YSW'(SCREEN_H));

  // Shared shifter: place the sprite byte at column x0, drop what falls off the edge
  assign spr_wide = {ram_q, {SCREEN_W{1'b0}}} >> x0;
  assign spr_mask = spr_wide[SCREEN_W+7:8];
  assign hit      = |(frame_eff & spr_mask);
  assign f_wdata  = frame_eff ^ spr_mask;

  always_comb begin
    ram_we    = accept && (kind == c8fed_pkg::KIND_WRITE_RAM);
    ram_waddr = RAM_AW'(fold(20'(address), 20'(RAM_BYTES)));
    ram_raddr = RAM_AW'(fold(20'(pc), 20'(RAM_BYTES)));
    v_we      = 1'b0;
    v_waddr   = opcode[11:8];
    v_wdata   = 8'h00;
    v_raddr   = reg_select;
    f_we      = 1'b0;
    f_raddr   = y_sum[ROW_AW-1:0];
    unique case (state)
      IDLE: begin
        f_raddr = row_select[ROW_AW-1:0];
      end
      FETCH_B: begin
        // wrap the second fetch byte at 12 bits before the RAM size fold
        ram_raddr = RAM_AW'(fold(20'(12'(pc + 12'd1)), 20'(RAM_BYTES)));
      end
      DECODE: begin
        if (dec_word[15:12] == c8fed_pkg::OP_SETV) begin
          v_we    = 1'b1;
          v_waddr = dec_word[11:8];
          v_wdata = dec_word[7:0];
        end
      end
      ADD_RD, DRAW_X: begin
        v_raddr = opcode[11:8];
      end
      ADD_WR: begin
        v_we    = 1'b1;
        v_wdata = v_eff + opcode[7:0];
      end
      DRAW_Y: begin
        v_raddr = opcode[7:4];
      end
      DRAW_Z: begin
        v_we    = 1'b1;
        v_waddr = c8fed_pkg::VF_IDX;
      end
      ROW_RD: begin
        ram_raddr = RAM_AW'(fold(20'(spr_addr), 20'(RAM_BYTES)));
      end
      ROW_WR: begin
        f_we = 1'b1;
        if (hit) begin
          v_we    = 1'b1;
          v_waddr = c8fed_pkg::VF_IDX;
          v_wdata = 8'h01;
        end
      end
      ROW_GET, REG_GET, FETCH_A, FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Program RAM
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= data;
    end
    ram_q <= ram_mem[ram_raddr];
  end

  // V register file
  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[v_waddr] <= v_wdata;
    end
    v_q <= v_mem[v_raddr];
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (f_we) begin
      frame_mem[y_sum[ROW_AW-1:0]] <= f_wdata;
    end
    frame_q <= frame_mem[f_raddr];
  end

  // Sequencer, architectural registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      pc           <= c8fed_pkg::PC_RESET;
      index        <= 12'h000;
      vf           <= 8'h00;
      vvalid       <= '0;
      fvalid       <= '0;
      v_rok        <= 1'b0;
      f_rok        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v_rok <= vvalid[v_raddr];
      f_rok <= (32'(f_raddr) < SCREEN_H) && fvalid[f_raddr];
      // drain the result register; the finish step reloads it itself
      if (result_valid && !result_stall && (state != FINISH)) begin
        result_valid <= 1'b0;
      end
      if (v_we) begin
        vvalid[v_waddr] <= 1'b1;
        if (v_waddr == c8fed_pkg::VF_IDX) begin
          vf <= v_wdata;
        end
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            opcode  <= 16'h0000;
            res_row <= 64'h0;
            res_reg <= 8'h00;
            row_sel <= row_select;
            unique case (kind)
              c8fed_pkg::KIND_WRITE_RAM: state <= FINISH;
              c8fed_pkg::KIND_EXECUTE:   state <= FETCH_A;
              c8fed_pkg::KIND_READ_ROW:  state <= ROW_GET;
              c8fed_pkg::KIND_READ_REG:  state <= REG_GET;
              default:                   state <= FINISH;
            endcase
          end
        end
        FETCH_A: begin
          state <= FETCH_B;
        end
        FETCH_B: begin
          op_hi <= ram_q;
          state <= DECODE;
        end
        DECODE: begin
          opcode <= dec_word;
          if (dec_word[15:12] == c8fed_pkg::OP_JUMP) begin
            pc <= dec_word[11:0];
          end else begin
            pc <= pc + 12'd2;
          end
          unique case (dec_word[15:12])
            c8fed_pkg::OP_SYS: begin
              if (dec_word == c8fed_pkg::WORD_CLS) begin
                fvalid <= '0;
              end
              state <= FINISH;
            end
            c8fed_pkg::OP_ADDV: state <= ADD_RD;
            c8fed_pkg::OP_SETI: begin
              index <= dec_word[11:0];
              state <= FINISH;
            end
            c8fed_pkg::OP_DRAW: state <= DRAW_X;
            default: begin
              state <= FINISH;
            end
          endcase
        end
        ADD_RD: begin
          state <= ADD_WR;
        end
        ADD_WR: begin
          state <= FINISH;
        end
        DRAW_X: begin
          state <= DRAW_Y;
        end
        DRAW_Y: begin
          x0    <= XW'(fold(20'(v_eff), 20'(SCREEN_W)));
          state <= DRAW_Z;
        end
        DRAW_Z: begin
          y0     <= ROW_AW'(fold(20'(v_eff), 20'(SCREEN_H)));
          draw_i <= 4'd0;
          state  <= ROW_RD;
        end
        ROW_RD: begin
          state <= draw_done ? FINISH : ROW_WR;
        end
        ROW_WR: begin
          fvalid[y_sum[ROW_AW-1:0]] <= 1'b1;
          draw_i <= draw_i + 4'd1;
          state  <= ROW_RD;
        end
        ROW_GET: begin
          if (32'(row_sel) < SCREEN_H) begin
            res_row <= 64'(frame_eff) << (64 - SCREEN_W);
          end
          state <= FINISH;
        end
        REG_GET: begin
          res_reg <= v_eff;
          state   <= FINISH;
        end
        FINISH: begin
          // hold until the result register is free or draining
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            pc_now       <= pc;
            index_now    <= index;
            opcode_run   <= opcode;
            collision    <= vf[0];
            row_bits     <= res_row;
            reg_value    <= res_reg;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Assertions
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item channel open right after a transfer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == FINISH))
    else $error("result raised outside the finish step");

  a_row_write_in_range: assert property (@(posedge clk) disable iff (rst)
    f_we |-> (y_sum < YSW'(SCREEN_H)) && (state == ROW_WR))
    else $error("frame write below the bottom edge");

  a_draw_row_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ROW_WR) |-> (draw_i != opcode[3:0]))
    else $error("sprite drew more rows than requested");

endmodule
